### rtl/stup_pkg.sv
// Package for the string to unsigned parser: phase codes, constants and character helpers.
package stup_pkg;

	// Default sizing of the top level
	localparam int VALUE_BITS_DEF   = 64;
	localparam int MAX_POSITION_DEF = 4095;

	localparam int BASE_W = 6;

	// Parse phases
	typedef enum logic [2:0] {
		PH_DONE   = 3'd0,
		PH_LEAD   = 3'd1,
		PH_PREFIX = 3'd2,
		PH_ZERO   = 3'd3,
		PH_DIGITS = 3'd4
	} phase_t;

	// Bases picked during prefix handling
	localparam logic [BASE_W-1:0] BASE_AUTO = 6'd0;
	localparam logic [BASE_W-1:0] BASE_OCT  = 6'd8;
	localparam logic [BASE_W-1:0] BASE_DEC  = 6'd10;
	localparam logic [BASE_W-1:0] BASE_HEX  = 6'd16;

	// Characters with a special role
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_X_LO  = 8'h78;
	localparam logic [7:0] CH_X_UP  = 8'h58;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} digit_t;

	// Hex digit decode: 0-9, a-f, A-F
	function automatic digit_t hex_digit(input logic [7:0] c);
		digit_t d;
		d.ok  = 1'b1;
		d.val = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			d.val = 4'(c - 8'h30);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			d.val = 4'(c - 8'h57);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			d.val = 4'(c - 8'h37);
		end else begin
			d.ok = 1'b0;
		end
		return d;
	endfunction

	// Space, tab, newline, carriage return, form feed, vertical tab
	function automatic logic is_blank(input logic [7:0] c);
		return (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) ||
		       (c == 8'h0D) || (c == 8'h0C) || (c == 8'h0B);
	endfunction

endpackage

### rtl/string_to_unsigned_parser.sv
// Top level of the streaming string to unsigned integer parser.
//
// Channel      | Dir | Handshake           | Contents
// s_*          | in  | s_tvalid / s_tready | tdata: char_in; tuser: string_start
// m_*          | out | m_tvalid / m_tready | tdata: parsed_value, stop_index, zero fill
// number_base_*| in  | number_base_wr      | number_base (radix, 0 = auto detect)
//
// One character word per cycle while no stopping character waits on m_tready.
// A word is held in the input register, then the parse step (one multiply-add
// of the accumulator by the base) updates the state and, on the stopping
// character, loads the result register, which drives the result stream.
// Reset puts the parser in the done phase; words are ignored until a string start.
// Words that produce no result keep flowing while a result waits on m_tready.
module string_to_unsigned_parser #(
	parameter int VALUE_BITS   = stup_pkg::VALUE_BITS_DEF,
	parameter int MAX_POSITION = stup_pkg::MAX_POSITION_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	// configuration
	input  logic       number_base_wr,
	input  logic [5:0] number_base_data,
	// input stream
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,          // [7:0] char_in
	input  logic       s_tuser,          // string_start
	// result stream
	output logic       m_tvalid,
	input  logic       m_tready,
	// parsed_value from bit 0, then stop_index, then zero fill to whole bytes
	output logic [((VALUE_BITS + $clog2(MAX_POSITION + 1) + 7) / 8) * 8 - 1:0] m_tdata
);

	localparam int POS_BITS = $clog2(MAX_POSITION + 1);
	localparam int DATA_W   = ((VALUE_BITS + POS_BITS + 7) / 8) * 8;
	localparam int PAD_W    = DATA_W - VALUE_BITS - POS_BITS;
	localparam int BW       = stup_pkg::BASE_W;
	localparam logic [POS_BITS-1:0] POS_MAX = POS_BITS'(MAX_POSITION);

	// configuration register
	logic [BW-1:0] number_base_q;

	// input register
	logic       valid_s1;
	logic [7:0] char_s1;
	logic       start_s1;

	// parse state
	stup_pkg::phase_t        phase_q;
	logic [BW-1:0]           base_q;
	logic                    minus_q;
	logic [VALUE_BITS-1:0]   acc_q;
	logic [POS_BITS-1:0]     pos_q;

	// result register
	logic                    m_valid_q;
	logic [DATA_W-1:0]       m_data_q;

	// step values after string start handling
	stup_pkg::phase_t        ph0;
	logic [BW-1:0]           base0;
	logic                    minus0;
	logic [VALUE_BITS-1:0]   acc0;
	logic [POS_BITS-1:0]     pos0;

	// next state
	stup_pkg::phase_t        nxt_phase;
	logic [BW-1:0]           nxt_base;
	logic                    nxt_minus;
	logic [VALUE_BITS-1:0]   nxt_acc;
	logic [POS_BITS-1:0]     nxt_pos;
	logic                    emit;
	logic                    adv;

	logic [VALUE_BITS-1:0]   res_value;
	logic [DATA_W-1:0]       res_data;

	// configuration write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			number_base_q <= '0;
		end else if (number_base_wr) begin
			number_base_q <= number_base_data;
		end
	end

	// the step can retire unless it makes a result that has nowhere to go
	assign adv      = valid_s1 && (!emit || !m_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			char_s1  <= s_tdata;
			start_s1 <= s_tuser;
		end
	end

	// string start resets the parse for this word
	always_comb begin
		ph0    = start_s1 ? stup_pkg::PH_LEAD : phase_q;
		base0  = start_s1 ? number_base_q : base_q;
		minus0 = start_s1 ? 1'b0 : minus_q;
		acc0   = start_s1 ? '0 : acc_q;
		pos0   = start_s1 ? '0 : pos_q;
	end

	// next state: sign, prefix, base detection and one digit step
	always_comb begin
		stup_pkg::phase_t           ph;
		logic [BW-1:0]              base;
		logic                       minus;
		logic                       go;
		stup_pkg::digit_t           dg;
		logic [VALUE_BITS+BW-1:0]   prod;
		ph        = ph0;
		base      = base0;
		minus     = minus0;
		go        = 1'b0;
		dg        = stup_pkg::hex_digit(char_s1);
		prod      = '0;
		nxt_phase = ph0;
		nxt_acc   = acc0;
		nxt_pos   = pos0;
		emit      = 1'b0;
		if (ph0 != stup_pkg::PH_DONE) begin
			nxt_pos = (pos0 < POS_MAX) ? pos0 + POS_BITS'(1) : pos0;
			go      = 1'b1;
			// leading blanks and optional sign
			if (ph == stup_pkg::PH_LEAD) begin
				if (stup_pkg::is_blank(char_s1)) begin
					go = 1'b0;
				end else if (char_s1 == stup_pkg::CH_PLUS ||
				             char_s1 == stup_pkg::CH_MINUS) begin
					minus     = (char_s1 == stup_pkg::CH_MINUS);
					nxt_phase = stup_pkg::PH_PREFIX;
					go        = 1'b0;
				end else begin
					ph = stup_pkg::PH_PREFIX;
				end
			end
			// leading zero may open a hex or octal prefix
			if (go && ph == stup_pkg::PH_PREFIX) begin
				if ((base == stup_pkg::BASE_AUTO || base == stup_pkg::BASE_HEX) &&
				    char_s1 == stup_pkg::CH_ZERO) begin
					nxt_phase = stup_pkg::PH_ZERO;
					go        = 1'b0;
				end else begin
					if (base == stup_pkg::BASE_AUTO) base = stup_pkg::BASE_DEC;
					ph = stup_pkg::PH_DIGITS;
				end
			end
			// 'x' after the zero selects hex
			if (go && ph == stup_pkg::PH_ZERO) begin
				if (char_s1 == stup_pkg::CH_X_LO || char_s1 == stup_pkg::CH_X_UP) begin
					base      = stup_pkg::BASE_HEX;
					nxt_phase = stup_pkg::PH_DIGITS;
					go        = 1'b0;
				end else begin
					if (base == stup_pkg::BASE_AUTO) base = stup_pkg::BASE_OCT;
					ph = stup_pkg::PH_DIGITS;
				end
			end
			// digit accumulate or stop
			if (go) begin
				prod = {{BW{1'b0}}, acc0} * {{VALUE_BITS{1'b0}}, base};
				if (dg.ok && {{(BW-4){1'b0}}, dg.val} < base) begin
					nxt_acc   = prod[VALUE_BITS-1:0] + VALUE_BITS'(dg.val);
					nxt_phase = stup_pkg::PH_DIGITS;
				end else begin
					nxt_phase = stup_pkg::PH_DONE;
					emit      = 1'b1;
				end
			end
		end
		nxt_base  = base;
		nxt_minus = minus;
	end

	// result word
	always_comb begin
		res_value = minus0 ? (VALUE_BITS'(0) - acc0) : acc0;
		res_data  = {{PAD_W{1'b0}}, pos0, res_value};
	end

	// parse state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= stup_pkg::PH_DONE;
			base_q  <= '0;
			minus_q <= 1'b0;
			acc_q   <= '0;
			pos_q   <= '0;
		end else if (adv) begin
			phase_q <= nxt_phase;
			base_q  <= nxt_base;
			minus_q <= nxt_minus;
			acc_q   <= nxt_acc;
			pos_q   <= nxt_pos;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (adv && emit) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			m_data_q <= res_data;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	// a stopping character ends the parse
	a_stop_done: assert property (@(posedge clk) disable iff (!arst_n)
		adv && emit |=> phase_q == stup_pkg::PH_DONE)
		else $error("parse not done after result");

	// a retired stopping character shows up as the next result word
	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		adv && emit |=> m_tvalid && m_tdata == $past(res_data))
		else $error("result word lost");

	// a pending result is never overwritten by a new one
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && !m_tready && valid_s1 && emit |-> !adv)
		else $error("pending result overwritten");

	// position counter saturates
	a_pos_sat: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_MAX)
		else $error("position beyond saturation");

endmodule
